@@ design/gld_pkg.sv @@
package gld_pkg;

   localparam int MAX_CODE_BITS_DEF = 12;
   localparam int DICT_DEPTH_DEF    = 4096;
   localparam int STACK_DEPTH_DEF   = 4096;

   localparam logic [1:0] ST_PIXEL   = 2'd0;
   localparam logic [1:0] ST_END     = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;
   localparam logic [1:0] ST_REFUSED = 2'd3;

   localparam logic [1:0] RUN_GOING   = 2'd0;
   localparam logic [1:0] RUN_ENDCODE = 2'd1;
   localparam logic [1:0] RUN_INVALID = 2'd2;
   localparam logic [1:0] RUN_TERM    = 2'd3;

   localparam logic [1:0] REG_MIN_CODE = 2'd0;
   localparam logic [1:0] REG_WIDTH    = 2'd1;
   localparam logic [1:0] REG_HEIGHT   = 2'd2;

   localparam logic CMD_PUSH  = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

   typedef struct packed {
      logic       cmd;
      logic [7:0] stream_byte;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  pixel;
      logic [15:0] column;
      logic [15:0] row;
      logic        last;
   } rsp_type;

endpackage

@@ design/gif_lzw_decoder.sv @@
// GIF LZW decoder. Push raw image-data sub-block bytes (length bytes included)
// with cmd 0; ask for pixels with cmd 1. A drain returns the next pixel with
// its column and row, or end of image / invalid code status, or nothing when
// no whole code is buffered yet. A data byte that arrives while more than 16
// bits are buffered is answered with status 3 and must be sent again.
// A drain that pops a pending pixel steps through dispatch, stack memory read,
// output and back to idle, and offers its item at the output step. A drain
// that must decode a code walks the code's prefix chain through the dictionary
// memories link by link, then pops; one item is in flight at a time. Writing
// min_code_size restarts the dictionary. Reset needs no clearing pass.
module gif_lzw_decoder #(
   parameter int MAX_CODE_BITS = gld_pkg::MAX_CODE_BITS_DEF,
   parameter int DICT_DEPTH    = gld_pkg::DICT_DEPTH_DEF,
   parameter int STACK_DEPTH   = gld_pkg::STACK_DEPTH_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  gld_pkg::req_type    req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output gld_pkg::rsp_type    rsp_data,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [15:0]         csr_data
);
   import gld_pkg::*;

   localparam int DA = $clog2(DICT_DEPTH);
   localparam int SA = $clog2(STACK_DEPTH);
   localparam int SC = SA + 1;
   localparam int NC = DA + 1;
   localparam int CW = MAX_CODE_BITS;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_POP   = 7'b0000010,
      S_DEC   = 7'b0000100,
      S_WALK  = 7'b0001000,
      S_WRD   = 7'b0010000,
      S_FIN   = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;

   logic [3:0]  min_ff, min_in;
   logic [15:0] width_ff, width_in, height_ff, height_in;
   logic [SC-1:0] sc_ff, sc_in;
   logic [23:0] buf_ff, buf_in;
   logic [4:0]  held_ff, held_in;
   logic [3:0]  cw_ff, cw_in;
   logic [NC-1:0] next_ff, next_in;
   logic [CW-1:0] prev_ff, prev_in;
   logic        havep_ff, havep_in;
   logic [7:0]  first_ff, first_in;
   logic [7:0]  left_ff, left_in;
   logic [15:0] col_ff, col_in, row_ff, row_in;
   logic [1:0]  stop_ff, stop_in;
   logic [CW-1:0] code_ff, code_in;   // current decode code
   logic [CW-1:0] walk_ff, walk_in;   // chain cursor
   logic        rvalid_ff, rvalid_in;
   rsp_type     rsp_ff, rsp_in;

   // memories
   logic          dict_we;
   logic [DA-1:0] dict_wa, dict_ra;
   logic [CW-1:0] pre_rd;
   logic [7:0]    suf_rd;
   logic          stk_we;
   logic [SA-1:0] stk_wa, stk_ra;
   logic [7:0]    stk_wd, stk_rd;

   gld_ram #(.WIDTH(CW), .DEPTH(DICT_DEPTH)) u_prefix (
      .clock(clock), .wr_en(dict_we), .wr_addr(dict_wa), .wr_data(prev_ff),
      .rd_addr(dict_ra), .rd_data(pre_rd));
   gld_ram #(.WIDTH(8), .DEPTH(DICT_DEPTH)) u_suffix (
      .clock(clock), .wr_en(dict_we), .wr_addr(dict_wa), .wr_data(first_in),
      .rd_addr(dict_ra), .rd_data(suf_rd));
   gld_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
      .clock(clock), .wr_en(stk_we), .wr_addr(stk_wa), .wr_data(stk_wd),
      .rd_addr(stk_ra), .rd_data(stk_rd));

   logic [3:0]  emin;
   logic [CW-1:0] clear_c, end_c;
   logic [CW-1:0] cur_code;
   logic [7:0]  top_byte;   // last pushed byte, tracked for first_char

   always_comb begin
      emin = (min_ff < 4'd2) ? 4'd2 : ((min_ff > 4'd8) ? 4'd8 : min_ff);
      clear_c = CW'(1) << emin;
      end_c = clear_c + CW'(1);
      cur_code = CW'(buf_ff & ((24'd1 << cw_ff) - 24'd1));
   end

   logic [7:0] last_push_ff, last_push_in;
   assign top_byte = last_push_ff;

   assign req_stall = (state_ff != S_IDLE) || (rvalid_ff && rsp_stall);
   assign rsp_valid = rvalid_ff;
   assign rsp_data  = rsp_ff;

   logic acc;
   assign acc = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      min_in = min_ff; width_in = width_ff; height_in = height_ff;
      sc_in = sc_ff; buf_in = buf_ff; held_in = held_ff; cw_in = cw_ff;
      next_in = next_ff; prev_in = prev_ff; havep_in = havep_ff;
      first_in = first_ff; left_in = left_ff; col_in = col_ff; row_in = row_ff;
      stop_in = stop_ff; code_in = code_ff; walk_in = walk_ff;
      last_push_in = last_push_ff;
      rvalid_in = rvalid_ff && rsp_stall;
      rsp_in = rsp_ff;
      dict_we = 1'b0; dict_wa = next_ff[DA-1:0]; dict_ra = walk_ff[DA-1:0];
      stk_we = 1'b0; stk_wa = sc_ff[SA-1:0]; stk_wd = 8'd0;
      stk_ra = SA'(sc_ff - SC'(1));

      case (state_ff)
         S_IDLE: begin
            if (acc) begin
               if (req_data.cmd == CMD_PUSH) begin
                  if (stop_ff == RUN_GOING) begin
                     if (left_ff == 8'd0) begin
                        if (req_data.stream_byte == 8'd0) stop_in = RUN_TERM;
                        else left_in = req_data.stream_byte;
                     end else if (held_ff > 5'd16) begin
                        rsp_in = '0;
                        rsp_in.status = ST_REFUSED;
                        rvalid_in = 1'b1;
                     end else begin
                        buf_in = buf_ff | (24'(req_data.stream_byte) << held_ff);
                        held_in = held_ff + 5'd8;
                        left_in = left_ff - 8'd1;
                     end
                  end
               end else begin
                  state_in = S_DEC;
               end
            end
         end
         S_DEC: begin
            // drain dispatch
            if (sc_ff != '0) begin
               stk_ra = SA'(sc_ff - SC'(1));
               sc_in = sc_ff - SC'(1);
               state_in = S_POP;
            end else if (stop_ff == RUN_ENDCODE || stop_ff == RUN_INVALID) begin
               rsp_in = '0; rsp_in.status = stop_ff; rvalid_in = 1'b1;
               state_in = S_IDLE;
            end else if ({1'b0, held_ff} >= {2'b0, cw_ff}) begin
               code_in = cur_code;
               buf_in = buf_ff >> cw_ff;
               held_in = held_ff - 5'(cw_ff);
               if (cur_code == clear_c) begin
                  cw_in = emin + 4'd1;
                  next_in = NC'(clear_c) + NC'(2);
                  havep_in = 1'b0; prev_in = '0;
               end else if (cur_code == end_c) begin
                  stop_in = RUN_ENDCODE;
               end else if (!havep_ff) begin
                  if (cur_code < clear_c) begin
                     stk_we = 1'b1; stk_wd = cur_code[7:0];
                     sc_in = sc_ff + SC'(1);
                     first_in = cur_code[7:0]; prev_in = cur_code;
                     havep_in = 1'b1;
                  end else begin
                     stop_in = RUN_INVALID; sc_in = '0;
                  end
               end else if (NC'(cur_code) > next_ff ||
                            (NC'(cur_code) == next_ff && next_ff >= NC'(DICT_DEPTH))) begin
                  stop_in = RUN_INVALID; sc_in = '0;
               end else if (NC'(cur_code) == next_ff) begin
                  stk_we = 1'b1; stk_wd = first_ff;
                  sc_in = sc_ff + SC'(1);
                  last_push_in = first_ff;
                  walk_in = prev_ff;
                  state_in = S_WALK;
               end else begin
                  walk_in = cur_code;
                  state_in = S_WALK;
               end
            end else if (stop_ff == RUN_TERM) begin
               rsp_in = '0; rsp_in.status = ST_END; rvalid_in = 1'b1;
               state_in = S_IDLE;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_WALK: begin
            if (walk_ff > end_c) begin
               dict_ra = walk_ff[DA-1:0];
               state_in = S_WRD;
            end else if (sc_ff >= SC'(STACK_DEPTH)) begin
               stop_in = RUN_INVALID; sc_in = '0; state_in = S_DEC;
            end else begin
               stk_we = 1'b1; stk_wd = walk_ff[7:0];
               sc_in = sc_ff + SC'(1);
               last_push_in = walk_ff[7:0];
               state_in = S_FIN;
            end
         end
         S_WRD: begin
            if (sc_ff >= SC'(STACK_DEPTH)) begin
               stop_in = RUN_INVALID; sc_in = '0; state_in = S_DEC;
            end else begin
               stk_we = 1'b1; stk_wd = suf_rd;
               sc_in = sc_ff + SC'(1);
               last_push_in = suf_rd;
               walk_in = pre_rd;
               state_in = S_WALK;
            end
         end
         S_FIN: begin
            first_in = top_byte;
            if (next_ff < NC'(DICT_DEPTH)) begin
               dict_we = 1'b1;
               next_in = next_ff + NC'(1);
               if (cw_ff < 4'(MAX_CODE_BITS) &&
                   next_in == (NC'(1) << cw_ff)) cw_in = cw_ff + 4'd1;
            end
            prev_in = code_ff;
            state_in = S_DEC;
         end
         S_POP: begin
            rsp_in.status = ST_PIXEL;
            rsp_in.pixel = stk_rd;
            rsp_in.column = col_ff;
            rsp_in.row = row_ff;
            rsp_in.last = (sc_ff == '0);
            if ({16'd0, col_ff} + 32'd1 >= {16'd0, width_ff}) begin
               col_in = '0;
               if (row_ff != 16'hFFFF) row_in = row_ff + 16'd1;
            end else begin
               col_in = col_ff + 16'd1;
            end
            if (row_ff < height_ff) begin
               rvalid_in = 1'b1;
               state_in = S_OUT;
            end else begin
               state_in = S_DEC;
            end
         end
         S_OUT: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase

      if (csr_write) begin
         case (csr_index)
            REG_MIN_CODE: begin
               min_in = csr_data[3:0];
               begin
                  cw_in = ((csr_data[3:0] < 4'd2) ? 4'd2 :
                           ((csr_data[3:0] > 4'd8) ? 4'd8 : csr_data[3:0])) + 4'd1;
                  next_in = (NC'(1) << (cw_in - 4'd1)) + NC'(2);
                  havep_in = 1'b0; prev_in = '0;
               end
            end
            REG_WIDTH:  width_in = csr_data;
            REG_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         min_ff <= 4'd8; width_ff <= 16'd1; height_ff <= 16'd1;
         sc_ff <= '0; buf_ff <= '0; held_ff <= '0;
         cw_ff <= 4'd9; next_ff <= NC'(258); prev_ff <= '0; havep_ff <= 1'b0;
         first_ff <= '0; left_ff <= '0; col_ff <= '0; row_ff <= '0;
         stop_ff <= RUN_GOING; rvalid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         min_ff <= min_in; width_ff <= (width_in == 16'd0) ? 16'd1 : width_in;
         height_ff <= height_in;
         sc_ff <= sc_in; buf_ff <= buf_in; held_ff <= held_in;
         cw_ff <= cw_in; next_ff <= next_in; prev_ff <= prev_in;
         havep_ff <= havep_in; first_ff <= first_in; left_ff <= left_in;
         col_ff <= col_in; row_ff <= row_in; stop_ff <= stop_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      walk_ff <= walk_in;
      rsp_ff <= rsp_in;
      last_push_ff <= last_push_in;
   end
endmodule

@@ design/gld_ram.sv @@
module gld_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ tb/tb_gif_lzw_decoder.sv @@
`default_nettype none

module tb_gif_lzw_decoder;
   import gld_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DICT_SIZE   = 4096;
   localparam int STACK_SIZE  = 4096;
   localparam int TOP_WIDTH   = 12;
   localparam int QUIET_WAIT  = 20000;   // worst drain that ends with no item out
   localparam int IDLE_LIMIT  = 100000;
   localparam int HOLD_CYCLES = 400;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   req_type    req_data;
   logic       rsp_valid;
   logic       rsp_stall;
   rsp_type    rsp_data;
   logic       csr_write;
   logic [1:0] csr_index;
   logic [15:0] csr_data;

   gif_lzw_decoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // ---------------------------------------------------------------------
   // Decoder mirror: tables, bit unpacker, counters, settings
   // ---------------------------------------------------------------------
   logic [11:0] lz_prefix [DICT_SIZE];
   logic [7:0]  lz_suffix [DICT_SIZE];
   logic [7:0]  lz_stack  [STACK_SIZE];
   int unsigned sp, bitbuf, nbits, cwidth, ncode, prevc, firstc;
   int unsigned blk_left, col_cnt, row_cnt;
   bit          havep;
   logic [1:0]  run_st;
   int unsigned min_reg    = 8;
   int unsigned width_reg  = 1;
   int unsigned height_reg = 1;

   rsp_type pixel_q [$];   // items still owed by the block
   int      errs = 0;

   function automatic int unsigned eff_min(int unsigned m);
      if (m < 2) return 2;
      if (m > 8) return 8;
      return m;
   endfunction

   function automatic void restart_dict();
      cwidth = eff_min(min_reg) + 1;
      ncode  = (1 << eff_min(min_reg)) + 2;
      havep  = 0;
      prevc  = 0;
   endfunction

   function automatic bit stack_push(int unsigned v);
      if (sp >= STACK_SIZE) return 0;
      lz_stack[sp] = v[7:0];
      sp++;
      return 1;
   endfunction

   function automatic bit chain_walk(int unsigned c, int unsigned endc);
      while (c > endc) begin
         if (c >= DICT_SIZE) return 0;
         if (!stack_push(lz_suffix[c])) return 0;
         c = lz_prefix[c];
      end
      return stack_push(c);
   endfunction

   function automatic void decode_one(int unsigned code);
      int unsigned clr;
      int unsigned endc;
      clr  = 1 << eff_min(min_reg);
      endc = clr + 1;
      if (code == clr) begin
         restart_dict();
         return;
      end
      if (code == endc) begin
         run_st = RUN_ENDCODE;
         return;
      end
      if (!havep) begin
         if (code < clr) begin
            void'(stack_push(code));
            firstc = code;
            prevc  = code;
            havep  = 1;
         end else begin
            run_st = RUN_INVALID;
            sp = 0;
         end
         return;
      end
      if (code > ncode || (code == ncode && ncode >= DICT_SIZE)) begin
         run_st = RUN_INVALID;
         sp = 0;
         return;
      end
      // KwKwK: string of the previous code plus its own first character
      if (code == ncode) begin
         if (!stack_push(firstc) || !chain_walk(prevc, endc)) begin
            run_st = RUN_INVALID;
            sp = 0;
            return;
         end
      end else if (!chain_walk(code, endc)) begin
         run_st = RUN_INVALID;
         sp = 0;
         return;
      end
      firstc = lz_stack[(sp - 1) % STACK_SIZE];
      if (ncode < DICT_SIZE) begin
         lz_prefix[ncode] = prevc[11:0];
         lz_suffix[ncode] = firstc[7:0];
         ncode++;
         if (cwidth < TOP_WIDTH && ncode == (1 << cwidth)) cwidth++;
      end
      prevc = code;
   endfunction

   // Works out what one accepted item returns; 1 when an item comes back.
   function automatic bit predict_item(req_type it, output rsp_type r);
      int unsigned px, col, row, code;
      r = '0;
      if (it.cmd == CMD_PUSH) begin
         if (run_st != RUN_GOING) return 0;
         if (blk_left == 0) begin
            if (it.stream_byte == 0) run_st = RUN_TERM;
            else blk_left = it.stream_byte;
            return 0;
         end
         if (nbits > 16) begin
            r.status = ST_REFUSED;
            return 1;
         end
         bitbuf = (bitbuf | (int'(it.stream_byte) << nbits)) & 32'hFF_FFFF;
         nbits += 8;
         blk_left--;
         return 0;
      end
      forever begin
         if (sp > 0) begin
            sp--;
            px  = lz_stack[sp % STACK_SIZE];
            col = col_cnt;
            row = row_cnt;
            if (col_cnt + 1 >= width_reg) begin
               col_cnt = 0;
               if (row_cnt < 16'hFFFF) row_cnt++;
            end else begin
               col_cnt++;
            end
            if (row < height_reg) begin
               r.status = ST_PIXEL;
               r.pixel  = px[7:0];
               r.column = col[15:0];
               r.row    = row[15:0];
               r.last   = (sp == 0);
               return 1;
            end
            continue;   // row past the image height: skip within this drain
         end
         if (run_st == RUN_ENDCODE || run_st == RUN_INVALID) begin
            r.status = (run_st == RUN_ENDCODE) ? ST_END : ST_INVALID;
            return 1;
         end
         if (nbits >= cwidth) begin
            code   = bitbuf & ((1 << cwidth) - 1);
            bitbuf = bitbuf >> cwidth;
            nbits -= cwidth;
            decode_one(code);
            continue;
         end
         if (run_st == RUN_TERM) begin
            r.status = ST_END;
            return 1;
         end
         return 0;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Stream builder: picks legal codes, packs them LSB first into sub-blocks
   // ---------------------------------------------------------------------
   int unsigned      g_min, g_width, g_next, g_n, g_zero, g_blk;
   bit               g_have;
   longint unsigned  g_acc;
   logic [7:0]       byte_q [$];

   function automatic void gen_restart();
      g_min   = eff_min(min_reg);
      g_width = g_min + 1;
      g_next  = (1 << g_min) + 2;
      g_have  = 0;
   endfunction

   function automatic void put_data(logic [7:0] b);
      int unsigned len;
      if (g_blk == 0) begin
         case ($urandom_range(0, 9))
            0:       len = 1;
            1:       len = 255;
            default: len = $urandom_range(2, 40);
         endcase
         byte_q = {byte_q, len[7:0]};
         g_blk = len;
      end
      byte_q = {byte_q, b};
      g_blk--;
   endfunction

   // Zero bits padded at the end of a phase are already in the block and
   // become the low bits of the next code.
   function automatic void emit_code(int unsigned c);
      int unsigned ov;
      int unsigned clr;
      clr = 1 << g_min;
      ov  = (g_zero < g_width) ? g_zero : g_width;
      g_acc  |= longint'(c >> ov) << g_n;
      g_n    += g_width - ov;
      g_zero -= ov;
      if (c == clr) begin
         gen_restart();
      end else if (c != clr + 1) begin
         if (!g_have) begin
            g_have = 1;
         end else if (g_next < DICT_SIZE) begin
            g_next++;
            if (g_width < TOP_WIDTH && g_next == (1 << g_width)) g_width++;
         end
      end
      while (g_n >= 8) begin
         put_data(g_acc[7:0]);
         g_acc = g_acc >> 8;
         g_n  -= 8;
      end
   endfunction

   function automatic int unsigned pick_literal();
      int unsigned ov;
      ov = (g_zero < g_width) ? g_zero : g_width;
      return $urandom_range(0, (1 << g_min) - 1) & ~((1 << ov) - 1);
   endfunction

   function automatic int unsigned pick_code();
      int unsigned clr, hi, c, span;
      clr = 1 << g_min;
      if (!g_have || g_zero > 0) return pick_literal();
      if ($urandom_range(0, 49) == 0) return clr;
      hi = (g_next < DICT_SIZE) ? g_next : DICT_SIZE - 1;
      if ($urandom_range(0, 1) == 1) begin
         // lean towards recent entries for longer strings
         span = hi - (clr + 2);
         if (span > 8) span = 8;
         c = hi - $urandom_range(0, span);
      end else begin
         c = $urandom_range(0, hi);
      end
      if (c == clr || c == clr + 1) c = hi;
      return c;
   endfunction

   // Completes the last byte; padding is kept shorter than a code.
   function automatic void flush_codes();
      while (((8 - g_n % 8) % 8) >= g_width) emit_code(pick_literal());
      if (g_n != 0) begin
         g_zero = 8 - g_n;
         put_data(g_acc[7:0]);
         g_acc = 0;
         g_n   = 0;
      end
   endfunction

   // ---------------------------------------------------------------------
   // Sender, register writes, receiver, checker, watchdog
   // ---------------------------------------------------------------------
   int  burst_left = 0;
   bit  hold_req = 0;
   bit  hold_taken = 0;
   int  hold_left = 0;

   task automatic send_item(input logic cmd, input logic [7:0] b,
                            output bit got, output rsp_type r);
      req_type it;
      int      gap;
      it.cmd = cmd;
      it.stream_byte = b;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= it;
      do @(posedge clock); while (req_stall);
      got = predict_item(it, r);
      if (got) pixel_q = {pixel_q, r};
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (QUIET_WAIT) @(posedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input int unsigned val);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val[15:0];
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         REG_MIN_CODE: begin
            min_reg = val & 4'hF;
            restart_dict();
            gen_restart();
         end
         REG_WIDTH:  width_reg  = val & 16'hFFFF;
         REG_HEIGHT: height_reg = val & 16'hFFFF;
         default: ;
      endcase
   endtask

   task automatic set_image(input int unsigned m, input int unsigned w, input int unsigned h);
      write_reg(REG_MIN_CODE, m);
      write_reg(REG_WIDTH, w);
      write_reg(REG_HEIGHT, h);
   endtask

   // Pushes the built stream with drains mixed in; a refused byte goes again.
   task automatic feed_stream(input int drain_pct);
      bit      got;
      bit      refused;
      rsp_type r;
      refused = 0;
      while (byte_q.size() != 0) begin
         if (refused || $urandom_range(0, 99) < drain_pct) begin
            send_item(CMD_DRAIN, $urandom_range(0, 255), got, r);
            refused = 0;
         end else begin
            send_item(CMD_PUSH, byte_q[0], got, r);
            refused = got && r.status == ST_REFUSED;
            if (!refused) void'(byte_q.pop_front());
         end
      end
      // stop once nothing is pending or a status comes back
      do send_item(CMD_DRAIN, $urandom_range(0, 255), got, r);
      while (got && r.status == ST_PIXEL);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_req && !hold_taken) begin
         hold_taken <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_stall  <= 1'b1;
      end else begin
         // stall pattern rotates through none, light and heavy
         case (($time / 128) % 3)
            0:       rsp_stall <= 1'b0;
            1:       rsp_stall <= ($urandom_range(0, 99) < 30);
            default: rsp_stall <= ($urandom_range(0, 99) < 70);
         endcase
      end
   end

   always @(posedge clock) begin : check_pixels
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixel_q.size() == 0) begin
            errs++;
            if (errs <= 10)
               $display("unexpected item: status %0d pixel %0d col %0d row %0d last %0d",
                        rsp_data.status, rsp_data.pixel, rsp_data.column,
                        rsp_data.row, rsp_data.last);
         end else begin
            e = pixel_q.pop_front();
            if (rsp_data.status !== e.status || rsp_data.pixel !== e.pixel ||
                rsp_data.column !== e.column || rsp_data.row !== e.row ||
                rsp_data.last !== e.last) begin
               errs++;
               if (errs <= 10)
                  $display({"mismatch: exp status %0d pixel %0d col %0d row %0d last %0d,",
                            " got status %0d pixel %0d col %0d row %0d last %0d"},
                           e.status, e.pixel, e.column, e.row, e.last,
                           rsp_data.status, rsp_data.pixel, rsp_data.column,
                           rsp_data.row, rsp_data.last);
            end
         end
      end
   end

   int idle_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb_gif_lzw_decoder failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Narrowest codes, largest literal, KwKwK twice, clears, a short image
   // so that later rows drop, and a flood of bytes until one is refused.
   task automatic test_directed();
      int unsigned codes [$];
      set_image(2, 3, 2);
      codes = '{4, 3, 0, 7, 1, 2, 4, 0, 6};
      foreach (codes[i]) emit_code(codes[i]);
      flush_codes();
      feed_stream(0);
      wait_quiet();
   endtask

   // Random legal streams over a range of settings, width and code size
   // extremes included; one phase holds the receiver off for a long time.
   task automatic test_random_streams();
      int unsigned mins [7];
      int unsigned w, h;
      mins = '{0, 8, 15, 5, 2, 3, 7};
      for (int p = 0; p < 7; p++) begin
         w = (p == 1) ? 65535 : $urandom_range(1, 40);
         h = (p == 4) ? row_cnt + $urandom_range(0, 3) : 65535;
         set_image(mins[p], w, h);
         if (p == 3) hold_req = 1;
         repeat (50) emit_code(pick_code());
         flush_codes();
         feed_stream($urandom_range(20, 60));
         wait_quiet();
      end
   endtask

   // Stops decoding by end code, block terminator or a bad first code;
   // bytes after that are ignored and drains keep giving the status.
   task automatic test_stop();
      bit      got;
      rsp_type r;
      int unsigned clr;
      clr = 1 << g_min;
      repeat (10) emit_code(pick_code());
      case ($urandom_range(0, 2))
         0: begin
            emit_code(clr + 1);
            flush_codes();
         end
         1: begin
            flush_codes();
            while (g_blk > 0) put_data(8'h00);
            byte_q = {byte_q, 8'h00};
         end
         default: begin
            emit_code(clr);
            emit_code(clr + 2);
            flush_codes();
         end
      endcase
      feed_stream(30);
      do send_item(CMD_DRAIN, 8'hFF, got, r); while (!(got && r.status != ST_PIXEL));
      repeat (3) send_item(CMD_PUSH, $urandom_range(0, 255), got, r);
      repeat (3) send_item(CMD_DRAIN, 8'h00, got, r);
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_write <= 1'b0;
      csr_index <= REG_MIN_CODE;
      csr_data  <= '0;
      sp = 0; bitbuf = 0; nbits = 0; firstc = 0; blk_left = 0;
      col_cnt = 0; row_cnt = 0; run_st = RUN_GOING;
      restart_dict();
      gen_restart();
      g_acc = 0; g_n = 0; g_zero = 0; g_blk = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random_streams();
      test_stop();

      req_valid <= 1'b0;
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errs == 0 && pixel_q.size() == 0) begin
         $display("tb_gif_lzw_decoder passed");
      end else begin
         $display("tb_gif_lzw_decoder failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

@@ gif_lzw_decoder.f @@
design/gld_pkg.sv
design/gld_ram.sv
design/gif_lzw_decoder.sv
tb/tb_gif_lzw_decoder.sv
